### hdl/mahd_pkg.sv
// ---------------------------------------------------------------------------
// MPEG audio header decoder package
// Types, constants and tables shared by the header decoder pipeline.
// ---------------------------------------------------------------------------
package mahd_pkg;

   // Header field widths.
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BR_W     = 19;
   localparam int unsigned SR_W     = 16;
   localparam int unsigned LEN_W    = 12;
   localparam int unsigned SPF_W    = 11;
   localparam int unsigned MULT_W   = 6;
   localparam int unsigned SLOTS_W  = 8;

   // Sanity check masks.
   localparam logic [WORD_W-1:0] SYNC_MASK   = 32'hffe0_0000;
   localparam logic [WORD_W-1:0] L1_REJ_MASK = 32'hffff_0000;
   localparam logic [WORD_W-1:0] L1_REJ_VAL  = 32'hfffe_0000;

   // Layer codes as they appear in bits 18:17.
   localparam logic [1:0] LAYER_CODE_RSVD = 2'd0;
   localparam logic [1:0] LAYER_CODE_L1   = 2'd3;

   // Version codes as they appear in bits 20:19.
   localparam logic [1:0] VER_CODE_MPEG1 = 2'd3;
   localparam logic [1:0] VER_CODE_MPEG2 = 2'd2;
   localparam logic [1:0] VER_CODE_RSVD  = 2'd1;

   // Sample-rate index codes.
   localparam logic [1:0] FREQ_44K  = 2'd0;
   localparam logic [1:0] FREQ_48K  = 2'd1;
   localparam logic [1:0] FREQ_32K  = 2'd2;
   localparam logic [1:0] FREQ_RSVD = 2'd3;

   localparam logic [3:0] BR_IDX_FREE = 4'd0;
   localparam logic [3:0] BR_IDX_BAD  = 4'd15;

   // Dense version numbering on the result port.
   typedef enum logic [1:0] {
      VER_MPEG1  = 2'd0,
      VER_MPEG2  = 2'd1,
      VER_MPEG25 = 2'd2
   } version_type;

   // Slot counts and samples per frame.
   localparam logic [SLOTS_W-1:0] SLOTS_L1   = 8'd12;
   localparam logic [SLOTS_W-1:0] SLOTS_FULL = 8'd144;
   localparam logic [SLOTS_W-1:0] SLOTS_LSF  = 8'd72;
   localparam logic [SPF_W-1:0]   SAMPLES_L1  = 11'd384;
   localparam logic [SPF_W-1:0]   SAMPLES_L23 = 11'd1152;

   // Every table bitrate is a multiple of this unit.
   localparam logic [12:0] RATE_UNIT = 13'd8000;

   // Base sample rates for MPEG-1; the later versions halve them per step.
   localparam logic [SR_W-1:0] SR_44K = 16'd44100;
   localparam logic [SR_W-1:0] SR_48K = 16'd48000;
   localparam logic [SR_W-1:0] SR_32K = 16'd32000;

   // Frame length divider. With n = slots * (bitrate / 8000) << shift the
   // length is n / 6 at 48 kHz family, n / 4 at 32 kHz family and
   // n * 80 / 441 at 44.1 kHz family.
   localparam int unsigned N_W   = 14;
   localparam int unsigned P_W   = 20;
   localparam int unsigned DIV_W = 9;
   localparam int unsigned Q_W   = 14;
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned K_W   = 23;
   localparam int unsigned PROD_W = P_W + K_W;

   localparam logic [6:0]       MUL_44K = 7'd80;
   localparam logic [DIV_W-1:0] DIV_44K = 9'd441;
   localparam logic [DIV_W-1:0] DIV_48K = 9'd6;
   localparam logic [DIV_W-1:0] DIV_32K = 9'd4;
   localparam logic [K_W-1:0] RECIP_44K = K_W'((64'd1 << RECIP_SHIFT) / 64'd441);
   localparam logic [K_W-1:0] RECIP_48K = K_W'((64'd1 << RECIP_SHIFT) / 64'd6);
   localparam logic [K_W-1:0] RECIP_32K = K_W'((64'd1 << RECIP_SHIFT) / 64'd4);

   // Bitrate table in units of 8000 bit/s. Rows: MPEG-1 layers I, II, III,
   // then low sample rate Layer I, then low sample rate Layers II and III.
   localparam int unsigned RATE_ROWS = 5;
   localparam logic [MULT_W-1:0] RATE_MULT [RATE_ROWS][16] = '{
      '{6'd0, 6'd4, 6'd8, 6'd12, 6'd16, 6'd20, 6'd24, 6'd28,
        6'd32, 6'd36, 6'd40, 6'd44, 6'd48, 6'd52, 6'd56, 6'd0},
      '{6'd0, 6'd4, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14,
        6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd40, 6'd48, 6'd0},
      '{6'd0, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12,
        6'd14, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd40, 6'd0},
      '{6'd0, 6'd4, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14,
        6'd16, 6'd18, 6'd20, 6'd22, 6'd24, 6'd28, 6'd32, 6'd0},
      '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
        6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd0}
   };

   // Stage 1: decoded header fields.
   typedef struct packed {
      logic               hv;
      version_type        ver;
      logic [1:0]         layer;
      logic [1:0]         mode;
      logic [BR_W-1:0]    br;
      logic [SR_W-1:0]    sr;
      logic [SPF_W-1:0]   spf;
      logic [MULT_W-1:0]  mult;
      logic [SLOTS_W-1:0] slots;
      logic [1:0]         fri;
      logic               pad;
   } dec_type;

   // Stage 2: numerator and divider selection.
   typedef struct packed {
      logic               hv;
      version_type        ver;
      logic [1:0]         layer;
      logic [1:0]         mode;
      logic [BR_W-1:0]    br;
      logic [SR_W-1:0]    sr;
      logic [SPF_W-1:0]   spf;
      logic               pad;
      logic [P_W-1:0]     num;
      logic [K_W-1:0]     recip;
      logic [DIV_W-1:0]   div;
   } num_type;

   // Stage 3: quotient estimate.
   typedef struct packed {
      logic               hv;
      version_type        ver;
      logic [1:0]         layer;
      logic [1:0]         mode;
      logic [BR_W-1:0]    br;
      logic [SR_W-1:0]    sr;
      logic [SPF_W-1:0]   spf;
      logic               pad;
      logic [P_W-1:0]     num;
      logic [DIV_W-1:0]   div;
      logic [Q_W-1:0]     qest;
   } quo_type;

   // Result register.
   typedef struct packed {
      logic               hv;
      version_type        ver;
      logic [1:0]         layer;
      logic [1:0]         mode;
      logic [BR_W-1:0]    br;
      logic [SR_W-1:0]    sr;
      logic [LEN_W-1:0]   len;
      logic [SPF_W-1:0]   spf;
   } res_type;

endpackage

### hdl/mpeg_audio_header_decode.sv
// ---------------------------------------------------------------------------
// MPEG audio header decoder
// Checks a 32-bit candidate frame header and decodes its fields.
// ---------------------------------------------------------------------------
// An accepted item passes the s1, s2, s3 and result registers to the rsp port.
// Throughput: one item per cycle while rsp_ready is high; the frame length
// divider, a reciprocal multiply and one correction step, spans three stages.
// Reset: synchronous, active high; it clears the stage valid bits only.
// Each stage holds its item while the next is full and stalled, so bubbles
// are squeezed out; the input stalls only once all four stages hold items.
// ---------------------------------------------------------------------------
module mpeg_audio_header_decode
   import mahd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [WORD_W-1:0]  req_header_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_header_valid,
   output logic [1:0]         rsp_version_code,
   output logic [1:0]         rsp_layer_number,
   output logic [1:0]         rsp_chan_mode,
   output logic [BR_W-1:0]    rsp_bitrate_bps,
   output logic [SR_W-1:0]    rsp_fs_hz,
   output logic [LEN_W-1:0]   rsp_frame_length,
   output logic [SPF_W-1:0]   rsp_samples_per_frame
);

   // Per-stage valid bits and payload registers.
   logic    s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   dec_type s1_in, s1_ff;
   num_type s2_in, s2_ff;
   quo_type s3_in, s3_ff;
   res_type out_in, out_ff;

   // A stage may load when it is empty or when the stage after it loads.
   logic out_en, s3_en, s2_en, s1_en;

   assign out_en    = !out_v_ff || rsp_ready;
   assign s3_en     = !s3_v_ff || out_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_ready = s1_en;

   // -----------------------------------------------------------------------
   // Stage 1: sanity checks and table lookups.
   // -----------------------------------------------------------------------
   logic [1:0]  ver_bits, lay_code, fri, mode_bits;
   logic [3:0]  bri;
   logic        pad, prot, pass;
   logic [2:0]  row;
   logic [1:0]  layer;
   version_type ver;
   logic [SR_W-1:0] sr_base;

   always_comb begin
      ver_bits  = req_header_word[20:19];
      lay_code  = req_header_word[18:17];
      prot      = req_header_word[16];
      bri       = req_header_word[15:12];
      fri       = req_header_word[11:10];
      pad       = req_header_word[9];
      mode_bits = req_header_word[7:6];

      // Every rule that makes a word unusable as a frame header.
      pass = ((req_header_word & SYNC_MASK) == SYNC_MASK)
          && (lay_code != LAYER_CODE_RSVD)
          && (bri != BR_IDX_FREE) && (bri != BR_IDX_BAD)
          && (fri != FREQ_RSVD)
          && !(req_header_word[19] && (lay_code == LAYER_CODE_L1) && prot)
          && ((req_header_word & L1_REJ_MASK) != L1_REJ_VAL)
          && (ver_bits != VER_CODE_RSVD);

      case (ver_bits)
         VER_CODE_MPEG1: ver = VER_MPEG1;
         VER_CODE_MPEG2: ver = VER_MPEG2;
         default:        ver = VER_MPEG25;
      endcase

      layer = 2'(3'd4 - {1'b0, lay_code});

      if (ver == VER_MPEG1) begin
         row = {1'b0, layer} - 3'd1;
      end else begin
         row = (layer == 2'd1) ? 3'd3 : 3'd4;
      end

      case (fri)
         FREQ_44K: sr_base = SR_44K;
         FREQ_48K: sr_base = SR_48K;
         default:  sr_base = SR_32K;
      endcase

      s1_in = '0;
      if (pass) begin
         s1_in.hv    = 1'b1;
         s1_in.ver   = ver;
         s1_in.layer = layer;
         s1_in.mode  = mode_bits;
         s1_in.mult  = RATE_MULT[row][bri];
         s1_in.br    = BR_W'(s1_in.mult) * BR_W'(RATE_UNIT);
         // Later versions halve the base sample rate once per step.
         s1_in.sr    = sr_base >> ver;
         s1_in.fri   = fri;
         s1_in.pad   = pad;
         if (layer == 2'd1) begin
            s1_in.slots = SLOTS_L1;
            s1_in.spf   = SAMPLES_L1;
         end else begin
            s1_in.slots = (layer == 2'd3 && ver != VER_MPEG1) ? SLOTS_LSF : SLOTS_FULL;
            s1_in.spf   = SAMPLES_L23;
         end
         if (ver != VER_MPEG1) begin
            s1_in.spf = s1_in.spf >> 1;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Stage 2: numerator slots * rate units, scaled by the version shift and
   // by 80 for 44.1 kHz; divider and reciprocal chosen by sample-rate family.
   // -----------------------------------------------------------------------
   logic [N_W-1:0] n_val;

   always_comb begin
      n_val = (N_W'(s1_ff.slots) * N_W'(s1_ff.mult)) << s1_ff.ver;

      s2_in.hv    = s1_ff.hv;
      s2_in.ver   = s1_ff.ver;
      s2_in.layer = s1_ff.layer;
      s2_in.mode  = s1_ff.mode;
      s2_in.br    = s1_ff.br;
      s2_in.sr    = s1_ff.sr;
      s2_in.spf   = s1_ff.spf;
      s2_in.pad   = s1_ff.pad;

      case (s1_ff.fri)
         FREQ_44K: begin
            s2_in.num   = P_W'(n_val) * P_W'(MUL_44K);
            s2_in.recip = RECIP_44K;
            s2_in.div   = DIV_44K;
         end
         FREQ_48K: begin
            s2_in.num   = P_W'(n_val);
            s2_in.recip = RECIP_48K;
            s2_in.div   = DIV_48K;
         end
         default: begin
            s2_in.num   = P_W'(n_val);
            s2_in.recip = RECIP_32K;
            s2_in.div   = DIV_32K;
         end
      endcase
   end

   // -----------------------------------------------------------------------
   // Stage 3: quotient estimate by reciprocal multiply. The estimate is the
   // true quotient or one less.
   // -----------------------------------------------------------------------
   logic [PROD_W-1:0] prod;

   always_comb begin
      prod = PROD_W'(s2_ff.num) * PROD_W'(s2_ff.recip);

      s3_in.hv    = s2_ff.hv;
      s3_in.ver   = s2_ff.ver;
      s3_in.layer = s2_ff.layer;
      s3_in.mode  = s2_ff.mode;
      s3_in.br    = s2_ff.br;
      s3_in.sr    = s2_ff.sr;
      s3_in.spf   = s2_ff.spf;
      s3_in.pad   = s2_ff.pad;
      s3_in.num   = s2_ff.num;
      s3_in.div   = s2_ff.div;
      s3_in.qest  = prod[RECIP_SHIFT +: Q_W];
   end

   // -----------------------------------------------------------------------
   // Stage 4: remainder check, padding slot and Layer I slot size.
   // -----------------------------------------------------------------------
   logic [Q_W+DIV_W-1:0] qd;
   logic [P_W-1:0]       rem;
   logic [Q_W-1:0]       quo, len_raw;

   always_comb begin
      qd      = (Q_W+DIV_W)'(s3_ff.qest) * (Q_W+DIV_W)'(s3_ff.div);
      rem     = s3_ff.num - P_W'(qd);
      quo     = s3_ff.qest + Q_W'(rem >= P_W'(s3_ff.div));
      len_raw = quo + Q_W'(s3_ff.pad);

      out_in.hv    = s3_ff.hv;
      out_in.ver   = s3_ff.ver;
      out_in.layer = s3_ff.layer;
      out_in.mode  = s3_ff.mode;
      out_in.br    = s3_ff.br;
      out_in.sr    = s3_ff.sr;
      out_in.spf   = s3_ff.spf;
      if (!s3_ff.hv) begin
         out_in.len = '0;
      end else if (s3_ff.layer == 2'd1) begin
         // Layer I slots are four bytes long.
         out_in.len = LEN_W'(len_raw << 2);
      end else begin
         out_in.len = LEN_W'(len_raw);
      end
   end

   // -----------------------------------------------------------------------
   // Registers.
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_v_ff  <= req_valid;
         if (s2_en)  s2_v_ff  <= s1_v_ff;
         if (s3_en)  s3_v_ff  <= s2_v_ff;
         if (out_en) out_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en)  s1_ff  <= s1_in;
      if (s2_en)  s2_ff  <= s2_in;
      if (s3_en)  s3_ff  <= s3_in;
      if (out_en) out_ff <= out_in;
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_header_valid      = out_ff.hv;
   assign rsp_version_code      = out_ff.ver;
   assign rsp_layer_number      = out_ff.layer;
   assign rsp_chan_mode         = out_ff.mode;
   assign rsp_bitrate_bps       = out_ff.br;
   assign rsp_fs_hz             = out_ff.sr;
   assign rsp_frame_length      = out_ff.len;
   assign rsp_samples_per_frame = out_ff.spf;

endmodule
